### hw/rtl/sads_pkg.sv
// shared types and constants for the two-stacks-in-one-store block
package sads_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned WORD_W       = 32;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // stack selectors
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic access;   // store access and pointer update
    logic load;     // fill the output register
  } dp_cmd_t;

endpackage

### hw/rtl/sads_ctrl.sv
// controller: sequences capture, store access and result load
module sads_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output sads_pkg::dp_cmd_t cmd
);
  import sads_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ACCESS = 3'b010,
    S_LOAD   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        // wait until the previous result has been taken
        if (slot_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/sads_dpath.sv
// datapath: shared store, the two occupancy counts and the result register
module sads_dpath #(
  parameter int unsigned CAPACITY = sads_pkg::DEF_CAPACITY,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sads_pkg::dp_cmd_t           cmd,
  input  logic                        req_type,
  input  logic                        stack_sel,
  input  logic [sads_pkg::WORD_W-1:0] push_value,
  output logic [sads_pkg::WORD_W-1:0] pop_value,
  output sads_pkg::status_t           status,
  output logic [CNT_W-1:0]            left_count,
  output logic [CNT_W-1:0]            right_count
);
  import sads_pkg::*;

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W:0]   CAP_S = (CNT_W + 1)'(CAPACITY);

  logic [WORD_W-1:0] mem [CAPACITY];

  logic              req_type_r;
  logic              stack_sel_r;
  logic [WORD_W-1:0] push_value_r;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [CNT_W-1:0]  right_r, right_nxt;
  logic [WORD_W-1:0] rd_data_r;
  status_t           acc_status_r, acc_status_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  logic [WORD_W-1:0] pop_value_r;
  status_t           status_r;
  logic [CNT_W-1:0]  left_count_r;
  logic [CNT_W-1:0]  right_count_r;

  logic [CNT_W:0]    total;
  logic              full;
  logic [CNT_W-1:0]  addr_wide;
  logic [ADDR_W-1:0] addr;
  logic              wr_en;

  assign total = {1'b0, left_r} + {1'b0, right_r};
  assign full  = (total >= CAP_S);

  always_comb begin
    acc_status_nxt = ST_OK;
    pop_ok_nxt     = 1'b0;
    wr_en          = 1'b0;
    left_nxt       = left_r;
    right_nxt      = right_r;
    addr_wide      = '0;
    if (req_type_r == REQ_PUSH) begin
      if (full) begin
        acc_status_nxt = ST_FULL;
      end else if (stack_sel_r == SEL_LEFT) begin
        addr_wide = left_r;
        wr_en     = 1'b1;
        left_nxt  = left_r + 1'b1;
      end else begin
        // right stack grows downward from the top entry
        addr_wide = CAP_C - right_r - 1'b1;
        wr_en     = 1'b1;
        right_nxt = right_r + 1'b1;
      end
    end else begin
      if (stack_sel_r == SEL_LEFT) begin
        if (left_r == '0) begin
          acc_status_nxt = ST_EMPTY;
        end else begin
          addr_wide  = left_r - 1'b1;
          pop_ok_nxt = 1'b1;
          left_nxt   = left_r - 1'b1;
        end
      end else begin
        if (right_r == '0) begin
          acc_status_nxt = ST_EMPTY;
        end else begin
          addr_wide  = CAP_C - right_r;
          pop_ok_nxt = 1'b1;
          right_nxt  = right_r - 1'b1;
        end
      end
    end
  end

  assign addr = addr_wide[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      if (wr_en) begin
        mem[addr] <= push_value_r;
      end
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r   <= req_type;
      stack_sel_r  <= stack_sel;
      push_value_r <= push_value;
    end
    if (cmd.access) begin
      acc_status_r <= acc_status_nxt;
      pop_ok_r     <= pop_ok_nxt;
    end
    if (cmd.load) begin
      pop_value_r   <= pop_ok_r ? rd_data_r : '0;
      status_r      <= acc_status_r;
      left_count_r  <= left_r;
      right_count_r <= right_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (cmd.access) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign pop_value   = pop_value_r;
  assign status      = status_r;
  assign left_count  = left_count_r;
  assign right_count = right_count_r;

endmodule

### hw/rtl/shared_array_double_stack.sv
// top level: two stacks sharing one store, stream in and stream out
//
//  channel | dir | tdata (low bit up)                       | tuser (low bit up)
//  in_     | in  | push_value                               | req_type, stack_sel
//  out_    | out | pop_value, left_count, right_count, pad  | status
//
// a request passes through capture, one store access and result load;
// the controller's three states, one registered step each, sequence these; a new
// word is taken while the previous result still waits in the output register
// synchronous active-low reset clears both counts and the controller;
// store contents are undefined until pushed
// a stalled output holds the controller in its load state
module shared_array_double_stack #(
  parameter int unsigned CAPACITY = sads_pkg::DEF_CAPACITY,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1),
  parameter int unsigned OUT_W    = ((sads_pkg::WORD_W + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sads_pkg::WORD_W-1:0] in_tdata,   // push_value
  input  logic [1:0]                  in_tuser,   // req_type, stack_sel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_W-1:0]            out_tdata,  // pop_value, left_count, right_count
  output logic [1:0]                  out_tuser   // status
);
  import sads_pkg::*;

  localparam int unsigned PAD_W = OUT_W - WORD_W - 2 * CNT_W;

  dp_cmd_t           cmd;
  logic [WORD_W-1:0] pop_value;
  status_t           status;
  logic [CNT_W-1:0]  left_count;
  logic [CNT_W-1:0]  right_count;

  sads_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sads_dpath #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_type    (in_tuser[0]),
    .stack_sel   (in_tuser[1]),
    .push_value  (in_tdata),
    .pop_value   (pop_value),
    .status      (status),
    .left_count  (left_count),
    .right_count (right_count)
  );

  generate
    if (PAD_W > 0) begin : g_pad
      assign out_tdata = {PAD_W'(0), right_count, left_count, pop_value};
    end else begin : g_nopad
      assign out_tdata = {right_count, left_count, pop_value};
    end
  endgenerate

  assign out_tuser = status;

endmodule
